// File: sv/csl_pkg.sv
// Shared types, character codes and keyword table for the C subset lexer.
package csl_pkg;

	// Default widths of the result fields.
	localparam int OFFSET_BITS_DEF = 20;
	localparam int VALUE_BITS_DEF  = 31;
	localparam int LENGTH_BITS_DEF = 8;

	// Most tokens one source byte can cause, and the keyword prefix store.
	localparam int MAX_RESULTS  = 3;
	localparam int PREFIX_CHARS = 6;
	localparam int PREFIX_BITS  = 8 * PREFIX_CHARS;
	localparam int KW_COUNT     = 6;

	// Scanner modes.
	typedef enum logic [3:0] {
		M_IDLE,
		M_WORD,
		M_NUM,
		M_OP,
		M_SLASH,
		M_LINE,
		M_BLOCK,
		M_STAR,
		M_ERR
	} mode_t;

	// Token kinds.
	localparam logic [2:0] K_PUNCT   = 3'd0;
	localparam logic [2:0] K_IDENT   = 3'd1;
	localparam logic [2:0] K_KEYWORD = 3'd2;
	localparam logic [2:0] K_NUMBER  = 3'd3;
	localparam logic [2:0] K_END     = 3'd4;
	localparam logic [2:0] K_ERROR   = 3'd5;

	// Characters with a meaning of their own.
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_LT    = 8'h3c;
	localparam logic [7:0] CH_GT    = 8'h3e;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_NL    = 8'h0a;

	// Keywords packed first character high, with their lengths.
	localparam logic [PREFIX_BITS-1:0] KW_PACK [KW_COUNT] = '{
		48'h0000_0000_6966,
		48'h0000_656c_7365,
		48'h0077_6869_6c65,
		48'h0000_0066_6f72,
		48'h7265_7475_726e,
		48'h0000_0069_6e74
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd2, 3'd4, 3'd5, 3'd3, 3'd6, 3'd3};

	// Result of a keyword lookup.
	typedef struct packed {
		logic       hit;
		logic [2:0] idx;
	} kw_hit_t;

	// Control from the scanner to the result queue.
	typedef struct packed {
		logic       load;
		logic [1:0] cnt;
	} obuf_ctl_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function automatic logic is_punct(input logic [7:0] c);
		return c == 8'h2b || c == 8'h2d || c == CH_STAR || c == 8'h28 || c == 8'h29 ||
			c == 8'h3b || c == 8'h7b || c == 8'h7d || c == 8'h26 || c == 8'h2c;
	endfunction

	function automatic logic is_op(input logic [7:0] c);
		return c == CH_EQ || c == CH_LT || c == CH_GT || c == CH_BANG;
	endfunction

	// Matches a word against the keyword table; len is the clamped word length.
	function automatic kw_hit_t kw_lookup(input logic [PREFIX_BITS-1:0] prefix,
			input logic [2:0] len);
		kw_hit_t r;
		r = '0;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			if (len == KW_LEN[k] && prefix == KW_PACK[k]) begin
				r.hit = 1'b1;
				r.idx = 3'(k);
			end
		end
		return r;
	endfunction

endpackage

// File: sv/csl_obuf.sv
// Three-entry result queue that hands the tokens of one byte out one beat at a time.
module csl_obuf #(
	parameter int DATA_BITS = 88
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  csl_pkg::obuf_ctl_t                             ctl,
	input  logic [csl_pkg::MAX_RESULTS-1:0][DATA_BITS-1:0] din,
	output logic                                           room,
	output logic                                           m_tvalid,
	input  logic                                           m_tready,
	output logic [DATA_BITS-1:0]                           m_tdata,
	output logic                                           m_tlast
);

	logic [1:0]                                     cnt_q;
	logic [csl_pkg::MAX_RESULTS-1:0][DATA_BITS-1:0] slot_q;
	logic                                           pop;

	// The head entry is on the bus; the final token of a byte carries tlast.
	assign m_tvalid = cnt_q != 2'd0;
	assign m_tdata  = slot_q[0];
	assign m_tlast  = cnt_q == 2'd1;
	assign pop      = m_tvalid && m_tready;

	// A new set may be loaded once the queue is empty after this edge.
	assign room = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_tready);

	// Fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (ctl.load) begin
			cnt_q <= ctl.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Entries shift towards the head as beats leave.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			slot_q <= din;
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> room)
		else $error("result queue loaded while still holding tokens");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !ctl.load && cnt_q > 2'd1) |=> cnt_q == $past(cnt_q) - 2'd1)
		else $error("result queue lost or repeated a token");

	a_show: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.load && ctl.cnt != 2'd0) |=> m_tvalid)
		else $error("loaded tokens not offered");

endmodule

// File: sv/c_subset_lexer.sv
// Top level of the C subset lexer: input register, scanner state and token formation.
//
// Channel | Dir | tdata (low bit up)                               | tlast
// s_      | in  | source_byte                                      | end_of_text
// m_      | out | token_kind, start_offset, token_length,          | last_of_run
//         |     | number_value, keyword_index, first_char,         |
//         |     | second_char, zero fill to whole bytes            |
//
// One byte is taken per cycle while each byte yields at most one token and m_tready is
// high. A byte that yields two or three tokens holds the input until the three-entry
// result queue, which hands out one token per beat, is down to its last. The first token
// of a byte is offered once the queue is loaded and can leave at the following edge.
// Reset clears the input register, the scanner state and the queue; no clearing pass.
// A stalled output keeps tokens in the queue and the input register then holds its byte.
module c_subset_lexer #(
	parameter int OFFSET_BITS = csl_pkg::OFFSET_BITS_DEF,
	parameter int VALUE_BITS  = csl_pkg::VALUE_BITS_DEF,
	parameter int LENGTH_BITS = csl_pkg::LENGTH_BITS_DEF,
	localparam int TOK_BITS   = 3 + OFFSET_BITS + LENGTH_BITS + VALUE_BITS + 3 + 8 + 8,
	localparam int DATA_BITS  = ((TOK_BITS + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // source_byte
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [DATA_BITS-1:0] m_tdata,   // kind, start, length, value, keyword, c1, c2
	output logic                 m_tlast
);

	localparam int PB = csl_pkg::PREFIX_BITS;
	localparam int NR = csl_pkg::MAX_RESULTS;

	// One token; the field declared last, kind, sits in the lowest bits.
	typedef struct packed {
		logic [7:0]             c2;
		logic [7:0]             c1;
		logic [2:0]             kw;
		logic [VALUE_BITS-1:0]  val;
		logic [LENGTH_BITS-1:0] len;
		logic [OFFSET_BITS-1:0] start;
		logic [2:0]             kind;
	} tok_t;

	function automatic tok_t mk_tok(input logic [2:0] kind, input logic [OFFSET_BITS-1:0] start,
			input logic [LENGTH_BITS-1:0] len, input logic [VALUE_BITS-1:0] val,
			input logic [2:0] kw, input logic [7:0] c1, input logic [7:0] c2);
		tok_t t;
		t.kind  = kind;
		t.start = start;
		t.len   = len;
		t.val   = val;
		t.kw    = kw;
		t.c1    = c1;
		t.c2    = c2;
		return t;
	endfunction

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Scanner state.
	csl_pkg::mode_t         mode_q, mode_d;
	logic [OFFSET_BITS-1:0] pos_q, pos_d;
	logic [OFFSET_BITS-1:0] start_q, start_d;
	logic [LENGTH_BITS-1:0] cnt_q, cnt_d;
	logic [VALUE_BITS-1:0]  acc_q, acc_d;
	logic [PB-1:0]          prefix_q, prefix_d;
	logic [7:0]             held_q, held_d;

	logic                      room;
	logic                      step_go;
	logic                      fresh;
	logic [1:0]                n;
	tok_t [NR-1:0]             res;
	logic [NR-1:0][DATA_BITS-1:0] din;
	csl_pkg::obuf_ctl_t        ctl;
	csl_pkg::kw_hit_t          kw_cur, kw_nxt;
	logic [2:0]                len_cur, len_nxt;
	logic [VALUE_BITS+3:0]     acc_x, acc_sum;
	logic [LENGTH_BITS-1:0]    cnt_inc;

	// The byte in the input register is worked once the queue can take its tokens.
	assign step_go  = valid_s1 && room;
	assign s_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Keyword lookup for the word now held.
	assign len_cur = (cnt_q < LENGTH_BITS'(7)) ? cnt_q[2:0] : 3'd7;
	assign kw_cur  = csl_pkg::kw_lookup(prefix_q, len_cur);

	// Decimal step: acc * 10 + digit by shift and add, saturating.
	assign acc_x   = (VALUE_BITS + 4)'(acc_q);
	assign acc_sum = (acc_x << 3) + (acc_x << 1) + (VALUE_BITS + 4)'(byte_s1[3:0]);
	assign cnt_inc = (cnt_q != '1) ? cnt_q + LENGTH_BITS'(1) : cnt_q;

	// Next state and the tokens caused by this byte.
	always_comb begin
		mode_d   = mode_q;
		pos_d    = pos_q + OFFSET_BITS'(1);
		start_d  = start_q;
		cnt_d    = cnt_q;
		acc_d    = acc_q;
		prefix_d = prefix_q;
		held_d   = held_q;
		n        = 2'd0;
		res      = '0;
		fresh    = 1'b0;
		len_nxt  = 3'd0;
		kw_nxt   = '0;

		unique case (mode_q)
			csl_pkg::M_ERR: begin
			end
			csl_pkg::M_LINE: begin
				if (byte_s1 == csl_pkg::CH_NL) mode_d = csl_pkg::M_IDLE;
			end
			csl_pkg::M_BLOCK: begin
				if (byte_s1 == csl_pkg::CH_STAR) mode_d = csl_pkg::M_STAR;
			end
			csl_pkg::M_STAR: begin
				if (byte_s1 == csl_pkg::CH_SLASH) mode_d = csl_pkg::M_IDLE;
				else if (byte_s1 != csl_pkg::CH_STAR) mode_d = csl_pkg::M_BLOCK;
			end
			csl_pkg::M_WORD: begin
				if (csl_pkg::is_alpha(byte_s1) || csl_pkg::is_digit(byte_s1)) begin
					if (cnt_q < LENGTH_BITS'(csl_pkg::PREFIX_CHARS))
						prefix_d = {prefix_q[PB-9:0], byte_s1};
					cnt_d = cnt_inc;
				end else begin
					res[n] = mk_tok(kw_cur.hit ? csl_pkg::K_KEYWORD : csl_pkg::K_IDENT,
						start_q, cnt_q, '0, kw_cur.hit ? kw_cur.idx : 3'd0, 8'd0, 8'd0);
					n = n + 2'd1;
					fresh = 1'b1;
				end
			end
			csl_pkg::M_NUM: begin
				if (csl_pkg::is_digit(byte_s1)) begin
					if (acc_sum > (VALUE_BITS + 4)'({VALUE_BITS{1'b1}}))
						acc_d = '1;
					else
						acc_d = acc_sum[VALUE_BITS-1:0];
					cnt_d = cnt_inc;
				end else begin
					res[n] = mk_tok(csl_pkg::K_NUMBER, start_q, cnt_q, acc_q, 3'd0, 8'd0, 8'd0);
					n = n + 2'd1;
					fresh = 1'b1;
				end
			end
			csl_pkg::M_OP: begin
				if (byte_s1 == csl_pkg::CH_EQ) begin
					res[n] = mk_tok(csl_pkg::K_PUNCT, start_q, LENGTH_BITS'(2), '0, 3'd0,
						held_q, csl_pkg::CH_EQ);
					n = n + 2'd1;
					mode_d = csl_pkg::M_IDLE;
				end else begin
					res[n] = mk_tok(csl_pkg::K_PUNCT, start_q, LENGTH_BITS'(1), '0, 3'd0,
						held_q, 8'd0);
					n = n + 2'd1;
					fresh = 1'b1;
				end
			end
			csl_pkg::M_SLASH: begin
				if (byte_s1 == csl_pkg::CH_SLASH) begin
					mode_d = csl_pkg::M_LINE;
				end else if (byte_s1 == csl_pkg::CH_STAR) begin
					mode_d = csl_pkg::M_BLOCK;
				end else begin
					res[n] = mk_tok(csl_pkg::K_PUNCT, start_q, LENGTH_BITS'(1), '0, 3'd0,
						csl_pkg::CH_SLASH, 8'd0);
					n = n + 2'd1;
					fresh = 1'b1;
				end
			end
			csl_pkg::M_IDLE: begin
				fresh = 1'b1;
			end
			default: begin
				fresh = 1'b1;
			end
		endcase

		// The byte begins something new.
		if (fresh) begin
			mode_d  = csl_pkg::M_IDLE;
			start_d = pos_q;
			priority if (csl_pkg::is_space(byte_s1)) begin
			end else if (byte_s1 == csl_pkg::CH_SLASH) begin
				mode_d = csl_pkg::M_SLASH;
			end else if (csl_pkg::is_punct(byte_s1)) begin
				res[n] = mk_tok(csl_pkg::K_PUNCT, pos_q, LENGTH_BITS'(1), '0, 3'd0,
					byte_s1, 8'd0);
				n = n + 2'd1;
			end else if (csl_pkg::is_op(byte_s1)) begin
				held_d = byte_s1;
				mode_d = csl_pkg::M_OP;
			end else if (csl_pkg::is_alpha(byte_s1)) begin
				prefix_d = PB'(byte_s1);
				cnt_d    = LENGTH_BITS'(1);
				mode_d   = csl_pkg::M_WORD;
			end else if (csl_pkg::is_digit(byte_s1)) begin
				acc_d  = VALUE_BITS'(byte_s1[3:0]);
				cnt_d  = LENGTH_BITS'(1);
				mode_d = csl_pkg::M_NUM;
			end else begin
				res[n] = mk_tok(csl_pkg::K_ERROR, pos_q, LENGTH_BITS'(1), '0, 3'd0,
					byte_s1, 8'd0);
				n = n + 2'd1;
				mode_d = csl_pkg::M_ERR;
			end
		end

		// Final byte: flush the pending token, send the end token, start over.
		if (last_s1) begin
			if (mode_d == csl_pkg::M_WORD) begin
				// The word as it stands after this byte is looked up before the state clears.
				len_nxt = (cnt_d < LENGTH_BITS'(7)) ? cnt_d[2:0] : 3'd7;
				kw_nxt  = csl_pkg::kw_lookup(prefix_d, len_nxt);
				res[n] = mk_tok(kw_nxt.hit ? csl_pkg::K_KEYWORD : csl_pkg::K_IDENT,
					start_d, cnt_d, '0, kw_nxt.hit ? kw_nxt.idx : 3'd0, 8'd0, 8'd0);
				n = n + 2'd1;
			end else if (mode_d == csl_pkg::M_NUM) begin
				res[n] = mk_tok(csl_pkg::K_NUMBER, start_d, cnt_d, acc_d, 3'd0, 8'd0, 8'd0);
				n = n + 2'd1;
			end else if (mode_d == csl_pkg::M_OP) begin
				res[n] = mk_tok(csl_pkg::K_PUNCT, start_d, LENGTH_BITS'(1), '0, 3'd0,
					held_d, 8'd0);
				n = n + 2'd1;
			end else if (mode_d == csl_pkg::M_SLASH) begin
				res[n] = mk_tok(csl_pkg::K_PUNCT, start_d, LENGTH_BITS'(1), '0, 3'd0,
					csl_pkg::CH_SLASH, 8'd0);
				n = n + 2'd1;
			end
			res[n] = mk_tok(csl_pkg::K_END, pos_d, '0, '0, 3'd0, 8'd0, 8'd0);
			n = n + 2'd1;
			mode_d   = csl_pkg::M_IDLE;
			pos_d    = '0;
			start_d  = '0;
			cnt_d    = '0;
			acc_d    = '0;
			prefix_d = '0;
			held_d   = '0;
		end
	end

	// Scanner state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= csl_pkg::M_IDLE;
			pos_q    <= '0;
			start_q  <= '0;
			cnt_q    <= '0;
			acc_q    <= '0;
			prefix_q <= '0;
			held_q   <= '0;
		end else if (step_go) begin
			mode_q   <= mode_d;
			pos_q    <= pos_d;
			start_q  <= start_d;
			cnt_q    <= cnt_d;
			acc_q    <= acc_d;
			prefix_q <= prefix_d;
			held_q   <= held_d;
		end
	end

	// Tokens widened to the bus with zero fill.
	always_comb begin
		for (int i = 0; i < NR; i++) din[i] = DATA_BITS'(res[i]);
	end

	assign ctl.load = step_go;
	assign ctl.cnt  = n;

	csl_obuf #(
		.DATA_BITS(DATA_BITS)
	) u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.din      (din),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// File: verif/c_subset_lexer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the C subset lexer: a directed text, then random texts, against a behavioural lexer.
module c_subset_lexer_test;

	localparam int DATA_BITS      = 88;
	localparam int DIRECTED_ROWS  = 25;
	localparam int RANDOM_BYTES   = 100;
	localparam int LONG_WORD_LEN  = 257;
	localparam int QUIET_LIMIT    = 2000;
	localparam int DRAIN_CYCLES   = 12;
	localparam int COUNT_MAX      = 255;
	localparam int PREFIX_LEN     = 6;
	localparam longint unsigned VALUE_MAX = 64'h7fff_ffff;

	// Idle percentages per phase: sender mostly busy first, then the receiver, then neither idles.
	localparam int SENDER_IDLE   [3] = '{25, 85, 0};
	localparam int RECEIVER_IDLE [3] = '{85, 25, 0};

	localparam string ALNUM = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
	localparam string PUNCT_SET = "+-*();{}&,/";
	localparam string OP_SET = "=<>!";
	localparam string COMMENT_SET = "**/a \n";

	typedef enum logic [2:0] {KEY_IF, KEY_ELSE, KEY_WHILE, KEY_FOR, KEY_RETURN, KEY_INT} keyword_t;

	// One token as it leaves the lexer.
	typedef struct packed {
		logic [2:0]  kind;
		logic [19:0] start;
		logic [7:0]  len;
		logic [30:0] val;
		logic [2:0]  kw;
		logic [7:0]  c1;
		logic [7:0]  c2;
		logic        run_end;
	} token_t;

	// One source byte, with a typed-in token where the outcome is obvious.
	typedef struct {
		logic [7:0] ch;
		logic       eot;
		bit         pinned;
		token_t     tok;
	} text_beat_t;

	localparam token_t NO_TOKEN = '0;

	// Directed text: error handling after reset, then every operator path and comment form.
	text_beat_t directed_rows [DIRECTED_ROWS] = '{
		'{8'h28, 1'b0, 1'b1, '{csl_pkg::K_PUNCT, 20'd0, 8'd1, 31'd0, 3'd0, 8'h28, 8'h00, 1'b1}},
		'{8'h00, 1'b0, 1'b1, '{csl_pkg::K_ERROR, 20'd1, 8'd1, 31'd0, 3'd0, 8'h00, 8'h00, 1'b1}},
		'{8'hff, 1'b0, 1'b0, NO_TOKEN},
		'{8'h78, 1'b1, 1'b1, '{csl_pkg::K_END, 20'd4, 8'd0, 31'd0, 3'd0, 8'h00, 8'h00, 1'b1}},
		'{8'h69, 1'b0, 1'b0, NO_TOKEN},
		'{8'h66, 1'b0, 1'b0, NO_TOKEN},
		'{8'h09, 1'b0, 1'b0, NO_TOKEN},
		'{8'h3c, 1'b0, 1'b0, NO_TOKEN},
		'{8'h3d, 1'b0, 1'b0, NO_TOKEN},
		'{8'h3e, 1'b0, 1'b0, NO_TOKEN},
		'{8'h37, 1'b0, 1'b0, NO_TOKEN},
		'{8'h61, 1'b0, 1'b0, NO_TOKEN},
		'{8'h2f, 1'b0, 1'b0, NO_TOKEN},
		'{8'h2a, 1'b0, 1'b0, NO_TOKEN},
		'{8'h2a, 1'b0, 1'b0, NO_TOKEN},
		'{8'h2f, 1'b0, 1'b0, NO_TOKEN},
		'{8'h2f, 1'b0, 1'b0, NO_TOKEN},
		'{8'h2f, 1'b0, 1'b0, NO_TOKEN},
		'{8'h80, 1'b0, 1'b0, NO_TOKEN},
		'{8'h0a, 1'b0, 1'b0, NO_TOKEN},
		'{8'h3d, 1'b0, 1'b0, NO_TOKEN},
		'{8'h2f, 1'b0, 1'b0, NO_TOKEN},
		'{8'h2b, 1'b0, 1'b0, NO_TOKEN},
		'{8'h5f, 1'b0, 1'b0, NO_TOKEN},
		'{8'h21, 1'b1, 1'b0, NO_TOKEN}
	};

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = 8'h00;   // source_byte
	logic                 s_tlast = 1'b0;    // end_of_text
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [DATA_BITS-1:0] m_tdata;           // kind, start, length, value, keyword, c1, c2
	logic                 m_tlast;           // last_of_run

	text_beat_t text_beats [$];
	token_t     tokens_due [$];
	token_t     batch [$];
	int         stall_phase = 0;
	int         bytes_taken = 0;
	int         quiet_cycles = 0;
	int         failures = 0;

	// Behavioural lexer state.
	csl_pkg::mode_t  lex_mode;
	logic [19:0]     lex_pos;
	logic [19:0]     tok_start;
	int unsigned     tok_count;
	longint unsigned num_acc;
	string           word_text;
	logic [7:0]      op_char;

	c_subset_lexer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic string keyword_text(keyword_t k);
		case (k)
			KEY_IF:     return "if";
			KEY_ELSE:   return "else";
			KEY_WHILE:  return "while";
			KEY_FOR:    return "for";
			KEY_RETURN: return "return";
			default:    return "int";
		endcase
	endfunction

	function automatic bit letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic bit digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit blank(logic [7:0] c);
		return c == " " || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function automatic bit single_punct(logic [7:0] c);
		return c == "+" || c == "-" || c == csl_pkg::CH_STAR || c == "(" || c == ")" ||
			c == ";" || c == "{" || c == "}" || c == "&" || c == ",";
	endfunction

	function automatic void reset_lexer();
		lex_mode = csl_pkg::M_IDLE;
		lex_pos = '0;
		tok_start = '0;
		tok_count = 0;
		num_acc = 0;
		word_text = "";
		op_char = 8'h00;
	endfunction

	function automatic void add_token(logic [2:0] kind, logic [19:0] start, int unsigned len,
			longint unsigned val, logic [2:0] kw, logic [7:0] c1, logic [7:0] c2);
		token_t t;
		t = '{kind, start, 8'(len), 31'(val), kw, c1, c2, 1'b0};
		batch.push_back(t);
	endfunction

	// A finished word is a keyword only when it spells one exactly.
	function automatic void add_word();
		bit         hit;
		logic [2:0] kw;
		string      kt;
		hit = 1'b0;
		kw = '0;
		for (int k = 0; k < csl_pkg::KW_COUNT; k++) begin
			kt = keyword_text(keyword_t'(k));
			if (tok_count == kt.len() && word_text == kt) begin
				hit = 1'b1;
				kw = 3'(k);
			end
		end
		if (hit)
			add_token(csl_pkg::K_KEYWORD, tok_start, tok_count, 0, kw, 8'h00, 8'h00);
		else
			add_token(csl_pkg::K_IDENT, tok_start, tok_count, 0, 3'd0, 8'h00, 8'h00);
	endfunction

	// Starts whatever token the byte opens while nothing is pending.
	function automatic void open_token(logic [7:0] c);
		lex_mode = csl_pkg::M_IDLE;
		tok_start = lex_pos;
		if (blank(c)) begin
		end else if (c == csl_pkg::CH_SLASH) begin
			lex_mode = csl_pkg::M_SLASH;
		end else if (single_punct(c)) begin
			add_token(csl_pkg::K_PUNCT, lex_pos, 1, 0, 3'd0, c, 8'h00);
		end else if (c == csl_pkg::CH_EQ || c == csl_pkg::CH_LT || c == csl_pkg::CH_GT ||
				c == csl_pkg::CH_BANG) begin
			op_char = c;
			lex_mode = csl_pkg::M_OP;
		end else if (letter(c)) begin
			word_text = $sformatf("%c", c);
			tok_count = 1;
			lex_mode = csl_pkg::M_WORD;
		end else if (digit(c)) begin
			num_acc = longint'(c - 8'h30);
			tok_count = 1;
			lex_mode = csl_pkg::M_NUM;
		end else begin
			add_token(csl_pkg::K_ERROR, lex_pos, 1, 0, 3'd0, c, 8'h00);
			lex_mode = csl_pkg::M_ERR;
		end
	endfunction

	// Advances the lexer by one source byte; the tokens it causes are left in batch.
	function automatic void lex_byte(logic [7:0] c, logic eot);
		longint unsigned d;
		batch.delete();
		case (lex_mode)
			csl_pkg::M_ERR: begin
			end
			csl_pkg::M_LINE: begin
				if (c == csl_pkg::CH_NL)
					lex_mode = csl_pkg::M_IDLE;
			end
			csl_pkg::M_BLOCK: begin
				if (c == csl_pkg::CH_STAR)
					lex_mode = csl_pkg::M_STAR;
			end
			csl_pkg::M_STAR: begin
				if (c == csl_pkg::CH_SLASH)
					lex_mode = csl_pkg::M_IDLE;
				else if (c != csl_pkg::CH_STAR)
					lex_mode = csl_pkg::M_BLOCK;
			end
			csl_pkg::M_WORD: begin
				if (letter(c) || digit(c)) begin
					if (tok_count < PREFIX_LEN)
						word_text = $sformatf("%s%c", word_text, c);
					if (tok_count < COUNT_MAX)
						tok_count++;
				end else begin
					add_word();
					open_token(c);
				end
			end
			csl_pkg::M_NUM: begin
				if (digit(c)) begin
					d = longint'(c - 8'h30);
					if (num_acc > (VALUE_MAX - d) / 10)
						num_acc = VALUE_MAX;
					else
						num_acc = num_acc * 10 + d;
					if (tok_count < COUNT_MAX)
						tok_count++;
				end else begin
					add_token(csl_pkg::K_NUMBER, tok_start, tok_count, num_acc, 3'd0,
						8'h00, 8'h00);
					open_token(c);
				end
			end
			csl_pkg::M_OP: begin
				if (c == csl_pkg::CH_EQ) begin
					add_token(csl_pkg::K_PUNCT, tok_start, 2, 0, 3'd0, op_char, csl_pkg::CH_EQ);
					lex_mode = csl_pkg::M_IDLE;
				end else begin
					add_token(csl_pkg::K_PUNCT, tok_start, 1, 0, 3'd0, op_char, 8'h00);
					open_token(c);
				end
			end
			csl_pkg::M_SLASH: begin
				if (c == csl_pkg::CH_SLASH) begin
					lex_mode = csl_pkg::M_LINE;
				end else if (c == csl_pkg::CH_STAR) begin
					lex_mode = csl_pkg::M_BLOCK;
				end else begin
					add_token(csl_pkg::K_PUNCT, tok_start, 1, 0, 3'd0, csl_pkg::CH_SLASH, 8'h00);
					open_token(c);
				end
			end
			default: open_token(c);
		endcase
		lex_pos = lex_pos + 20'd1;

		// The final byte flushes a pending token, closes the text and starts afresh.
		if (eot) begin
			case (lex_mode)
				csl_pkg::M_WORD:  add_word();
				csl_pkg::M_NUM:   add_token(csl_pkg::K_NUMBER, tok_start, tok_count, num_acc,
					3'd0, 8'h00, 8'h00);
				csl_pkg::M_OP:    add_token(csl_pkg::K_PUNCT, tok_start, 1, 0, 3'd0, op_char,
					8'h00);
				csl_pkg::M_SLASH: add_token(csl_pkg::K_PUNCT, tok_start, 1, 0, 3'd0,
					csl_pkg::CH_SLASH, 8'h00);
				default: begin
				end
			endcase
			add_token(csl_pkg::K_END, lex_pos, 0, 0, 3'd0, 8'h00, 8'h00);
			reset_lexer();
		end
		if (batch.size() > 0)
			batch[batch.size() - 1].run_end = 1'b1;
	endfunction

	function automatic void push_text(logic [7:0] txt [$]);
		text_beat_t b;
		foreach (txt[i]) begin
			b = '{txt[i], i == txt.size() - 1, 1'b0, NO_TOKEN};
			text_beats.push_back(b);
		end
	endfunction

	// Builds one random text, mostly well-formed tokens with some noise and broken comments.
	function automatic void add_random_text();
		logic [7:0] txt [$];
		int         pick;
		int         v;
		string      w;
		repeat ($urandom_range(1, 12)) begin
			pick = $urandom_range(0, 99);
			if (pick < 14) begin
				w = keyword_text(keyword_t'($urandom_range(0, csl_pkg::KW_COUNT - 1)));
				for (int k = 0; k < w.len(); k++)
					txt.push_back(w[k]);
				if ($urandom_range(0, 3) == 0)
					txt.push_back(ALNUM[$urandom_range(0, 62)]);
			end else if (pick < 28) begin
				txt.push_back(ALNUM[$urandom_range(0, 52)]);
				repeat ($urandom_range(0, 8))
					txt.push_back(ALNUM[$urandom_range(0, 62)]);
			end else if (pick < 40) begin
				// Numbers around the saturation point as well as short ones.
				v = $urandom_range(0, 7);
				if (v < 2) begin
					w = (v == 0) ? "2147483647" : "214748364";
					for (int k = 0; k < w.len(); k++)
						txt.push_back(w[k]);
				end
				repeat ((v == 7) ? $urandom_range(9, 12) : $urandom_range(v < 2 ? 0 : 1, 4))
					txt.push_back(8'h30 + 8'($urandom_range(0, 9)));
			end else if (pick < 52) begin
				txt.push_back(OP_SET[$urandom_range(0, 3)]);
				if ($urandom_range(0, 1) == 1)
					txt.push_back(csl_pkg::CH_EQ);
			end else if (pick < 66) begin
				txt.push_back(PUNCT_SET[$urandom_range(0, 10)]);
			end else if (pick < 80) begin
				repeat ($urandom_range(1, 3)) begin
					v = $urandom_range(8, 13);
					txt.push_back(v == 8 ? 8'h20 : 8'(v));
				end
			end else if (pick < 88) begin
				txt.push_back(csl_pkg::CH_SLASH);
				txt.push_back(csl_pkg::CH_STAR);
				repeat ($urandom_range(0, 6)) begin
					if ($urandom_range(0, 4) == 0)
						txt.push_back(8'($urandom_range(0, 255)));
					else
						txt.push_back(COMMENT_SET[$urandom_range(0, 5)]);
				end
				txt.push_back(csl_pkg::CH_STAR);
				txt.push_back(csl_pkg::CH_SLASH);
			end else if (pick < 94) begin
				txt.push_back(csl_pkg::CH_SLASH);
				txt.push_back(csl_pkg::CH_SLASH);
				repeat ($urandom_range(0, 6)) begin
					v = $urandom_range(0, 255);
					txt.push_back(v == csl_pkg::CH_NL ? 8'h0b : 8'(v));
				end
				txt.push_back(csl_pkg::CH_NL);
			end else if (pick < 97) begin
				txt.push_back(8'($urandom_range(0, 255)));
			end else begin
				txt.push_back(csl_pkg::CH_SLASH);
				txt.push_back(8'($urandom_range(32, 126)));
			end
			if ($urandom_range(0, 9) < 4)
				txt.push_back(8'h20);
		end

		// Now and then the text ends inside a comment.
		if ($urandom_range(0, 7) == 0) begin
			txt.push_back(csl_pkg::CH_SLASH);
			txt.push_back($urandom_range(0, 1) ? csl_pkg::CH_STAR : csl_pkg::CH_SLASH);
			txt.push_back(ALNUM[$urandom_range(0, 62)]);
		end
		push_text(txt);
	endfunction

	function automatic void check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endfunction

	// Receiver: stalls at random according to the phase.
	always @(posedge clk)
		m_tready <= ($urandom_range(0, 99) >= RECEIVER_IDLE[stall_phase]);

	// Both channels are observed at each edge; the watchdog counts edges with no beat.
	always @(posedge clk) begin
		token_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				lex_byte(s_tdata, s_tlast);
				if (text_beats[bytes_taken].pinned)
					tokens_due.push_back(text_beats[bytes_taken].tok);
				else
					foreach (batch[i])
						tokens_due.push_back(batch[i]);
				bytes_taken++;
			end
			if (m_tvalid && m_tready) begin
				if (tokens_due.size() == 0) begin
					$error("token with nothing due: kind %0d at offset %0d",
						m_tdata[2:0], m_tdata[22:3]);
					failures++;
				end else begin
					want = tokens_due.pop_front();
					check_field("token_kind", want.kind, m_tdata[2:0]);
					check_field("start_offset", want.start, m_tdata[22:3]);
					check_field("token_length", want.len, m_tdata[30:23]);
					check_field("number_value", want.val, m_tdata[61:31]);
					check_field("keyword_index", want.kw, m_tdata[64:62]);
					check_field("first_char", want.c1, m_tdata[72:65]);
					check_field("second_char", want.c2, m_tdata[80:73]);
					check_field("last_of_run", want.run_end, m_tlast);
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[c_subset_lexer] ERROR");
				$finish;
			end
		end
	end

	// Stimulus, sender and end of run.
	initial begin
		int idx;
		int total;
		logic [7:0] long_word [$];

		reset_lexer();
		foreach (directed_rows[i])
			text_beats.push_back(directed_rows[i]);
		while (text_beats.size() < DIRECTED_ROWS + RANDOM_BYTES / 2)
			add_random_text();

		// One word long enough to saturate the length field.
		long_word.push_back(ALNUM[$urandom_range(0, 52)]);
		repeat (LONG_WORD_LEN - 1)
			long_word.push_back(ALNUM[$urandom_range(0, 62)]);
		push_text(long_word);
		while (text_beats.size() < DIRECTED_ROWS + RANDOM_BYTES + LONG_WORD_LEN)
			add_random_text();
		total = text_beats.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// A beat on offer is held until taken; otherwise the sender may idle.
		idx = 0;
		while (idx < total) begin
			@(posedge clk);
			if (s_tvalid && s_tready)
				idx++;
			stall_phase <= (idx < total) ? (idx * 3) / total : 2;
			if (idx == total) begin
				s_tvalid <= 1'b0;
			end else if (!(s_tvalid && !s_tready)) begin
				if ($urandom_range(0, 99) < SENDER_IDLE[stall_phase]) begin
					s_tvalid <= 1'b0;
				end else begin
					s_tvalid <= 1'b1;
					s_tdata <= text_beats[idx].ch;
					s_tlast <= text_beats[idx].eot;
				end
			end
		end

		// Wait on the clock so that the tokens of the final byte are already due.
		@(posedge clk);
		while (tokens_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && tokens_due.size() == 0)
			$display("[c_subset_lexer] OK");
		else
			$display("[c_subset_lexer] ERROR");
		$finish;
	end

endmodule
